@@ rtl/core/mexset_pkg.sv @@
`timescale 1ns / 1ps

package mexset_pkg;

    // Field widths of one command and one result
    localparam int CMD_W     = 2;
    localparam int VALUE_W   = 16;
    localparam int MEX_OUT_W = 11;

    // Bitmap word geometry
    localparam int WORD_W   = 32;
    localparam int BITSEL_W = 5;

    // Default set size
    localparam int SET_SIZE_DEF = 1024;

    typedef logic [CMD_W-1:0] cmd_t;

    // Command codes
    localparam cmd_t CMD_INSERT = 2'd0;
    localparam cmd_t CMD_ERASE  = 2'd1;
    localparam cmd_t CMD_TEST   = 2'd2;
    localparam cmd_t CMD_CLEAR  = 2'd3;

    // Position of the lowest clear bit of a word; only meaningful when one exists
    function automatic logic [BITSEL_W-1:0] first_zero(input logic [WORD_W-1:0] w);
        logic [BITSEL_W-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                pos = BITSEL_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

@@ rtl/core/mexset_req_if.sv @@
`timescale 1ns / 1ps

interface mexset_req_if
    import mexset_pkg::*;
();
    logic               valid;
    logic               ready;
    cmd_t               cmd;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

@@ rtl/core/mexset_rsp_if.sv @@
`timescale 1ns / 1ps

interface mexset_rsp_if
    import mexset_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 outcome;
    logic [MEX_OUT_W-1:0] mex_value;
    logic                 out_of_range;

    modport source (output valid, output outcome, output mex_value, output out_of_range,
                    input ready);
    modport sink   (input valid, input outcome, input mex_value, input out_of_range,
                    output ready);
endinterface

@@ rtl/core/mex_tracking_integer_set_unit.sv @@
`timescale 1ns / 1ps

// Set of integers 0..SET_SIZE-1 that keeps its minimum excluded value (mex). Each request
// (insert, erase, test, clear) gives one response with the outcome flag, the mex after the
// command and an out-of-range flag. Membership lives in a RAM of 32-bit words,
// WORD_COUNT = ceil(SET_SIZE/32) deep, with one read and one write port. Test, erase and
// insert of a value other than the mex pass through ST_LOOK and ST_DONE before the response
// is loaded into the output register; out-of-range commands go from ST_IDLE straight to
// ST_DONE. Insert of the mex advances the mex by walking the bitmap one word per cycle
// through a shared lowest-zero finder, reading at most WORD_COUNT - 1 further words. Clear,
// and the clearing pass after reset, write every word once (32 words at the default size),
// during which no request is taken; a clear then responds through ST_DONE. The unit
// holds one command at a time; the next request is taken in the cycle after the response
// is loaded, and a finished response waits in the output register while that request is
// taken. A response still held by the receiver when the next one is ready stalls the unit.
module mex_tracking_integer_set_unit
    import mexset_pkg::*;
#(
    parameter int SET_SIZE = SET_SIZE_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    mexset_req_if.sink     req,
    mexset_rsp_if.source   rsp
);
    localparam int WORD_COUNT = (SET_SIZE + WORD_W - 1) / WORD_W;
    localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int MEX_W      = $clog2(SET_SIZE + 1);
    localparam int EXT_W      = VALUE_W + 1;
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(WORD_COUNT - 1);
    localparam logic [EXT_W-1:0]  SIZE_EXT  = EXT_W'(SET_SIZE);

    // Sequencer states
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_LOOK = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic [ADDR_W-1:0]  scan_addr_reg, scan_addr_next;
    logic               scan_first_reg, scan_first_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               clr_pend_reg, clr_pend_next;
    logic               res_outcome_reg, res_outcome_next;
    logic               res_oor_reg, res_oor_next;
    logic [MEX_W-1:0]   mex_reg, mex_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_outcome_reg, out_outcome_next;
    logic [MEX_OUT_W-1:0] out_mex_reg, out_mex_next;
    logic               out_oor_reg, out_oor_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic                accept;
    logic                in_oor;
    logic [ADDR_W-1:0]   in_word;
    logic [ADDR_W-1:0]   val_word;
    logic [WORD_W-1:0]   bit_mask;
    logic                cur_bit;
    logic [WORD_W-1:0]   scan_src;
    logic                scan_hit;
    logic [EXT_W-1:0]    scan_cand;
    logic [EXT_W-1:0]    value_ext;
    logic [EXT_W-1:0]    mex_ext;
    logic                slot_free;
    logic [MEX_W+MEX_OUT_W-1:0] mex_wide;

    mexset_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode the request and the held command
    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign in_oor    = ({1'b0, req.value} >= SIZE_EXT);
    assign in_word   = ADDR_W'(req.value[VALUE_W-1:BITSEL_W]);
    assign val_word  = ADDR_W'(value_reg[VALUE_W-1:BITSEL_W]);
    assign bit_mask  = WORD_W'(1) << value_reg[BITSEL_W-1:0];
    assign cur_bit   = ram_rdata[value_reg[BITSEL_W-1:0]];
    assign value_ext = {1'b0, value_reg};
    assign mex_ext   = EXT_W'(mex_reg);

    // Shared lowest-zero search over the current scan word
    assign scan_src  = scan_first_reg ? word_reg : ram_rdata;
    assign scan_hit  = (~scan_src != '0);
    assign scan_cand = EXT_W'({scan_addr_reg, first_zero(scan_src)});

    assign slot_free = !out_valid_reg || rsp.ready;

    // Read the requested word on transfer, the following word while scanning
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            ram_raddr = in_word;
        end
        else if (scan_addr_reg == LAST_WORD)
        begin
            ram_raddr = scan_addr_reg;
        end
        else
        begin
            ram_raddr = scan_addr_reg + ADDR_W'(1);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        value_next       = value_reg;
        word_next        = word_reg;
        scan_addr_next   = scan_addr_reg;
        scan_first_next  = scan_first_reg;
        clr_addr_next    = clr_addr_reg;
        clr_pend_next    = clr_pend_reg;
        res_outcome_next = res_outcome_reg;
        res_oor_next     = res_oor_reg;
        mex_next         = mex_reg;
        out_outcome_next = out_outcome_reg;
        out_mex_next     = out_mex_reg;
        out_oor_next     = out_oor_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        ram_we           = 1'b0;
        ram_waddr        = val_word;
        ram_wdata        = ram_rdata;

        case (state_reg)
            ST_CLR:
            begin
                // Sweep zeros through the bitmap
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == LAST_WORD)
                begin
                    mex_next      = '0;
                    clr_pend_next = 1'b0;
                    if (clr_pend_reg)
                    begin
                        res_outcome_next = 1'b1;
                        res_oor_next     = 1'b0;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.cmd;
                    value_next = req.value;
                    if (req.cmd == CMD_CLEAR)
                    begin
                        clr_addr_next = '0;
                        clr_pend_next = 1'b1;
                        state_next    = ST_CLR;
                    end
                    else if (in_oor)
                    begin
                        res_outcome_next = 1'b0;
                        res_oor_next     = 1'b1;
                        state_next       = ST_DONE;
                    end
                    else
                    begin
                        res_oor_next = 1'b0;
                        state_next   = ST_LOOK;
                    end
                end
            end

            ST_LOOK:
            begin
                state_next = ST_DONE;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        res_outcome_next = !cur_bit;
                        if (!cur_bit)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | bit_mask;
                            if (value_ext == mex_ext)
                            begin
                                // Everything below the mex is present: start from this word
                                word_next       = ram_rdata | bit_mask;
                                scan_addr_next  = val_word;
                                scan_first_next = 1'b1;
                                state_next      = ST_SCAN;
                            end
                        end
                    end
                    CMD_ERASE:
                    begin
                        res_outcome_next = cur_bit;
                        if (cur_bit)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~bit_mask;
                            if (value_ext < mex_ext)
                            begin
                                mex_next = MEX_W'(value_reg);
                            end
                        end
                    end
                    CMD_TEST:
                    begin
                        res_outcome_next = cur_bit;
                    end
                    default:
                    begin
                        res_outcome_next = 1'b1;
                    end
                endcase
            end

            ST_SCAN:
            begin
                // Walk the words until a clear bit or the end of the set
                scan_first_next = 1'b0;
                if (scan_hit)
                begin
                    mex_next   = (scan_cand >= SIZE_EXT) ? MEX_W'(SET_SIZE) : MEX_W'(scan_cand);
                    state_next = ST_DONE;
                end
                else if (scan_addr_reg == LAST_WORD)
                begin
                    mex_next   = MEX_W'(SET_SIZE);
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + ADDR_W'(1);
                end
            end

            ST_DONE:
            begin
                // Hand the response to the output register once it is free
                if (slot_free)
                begin
                    out_valid_next   = 1'b1;
                    out_outcome_next = res_outcome_reg;
                    out_mex_next     = mex_wide[MEX_OUT_W-1:0];
                    out_oor_next     = res_oor_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mex_wide = {{MEX_OUT_W{1'b0}}, mex_reg};

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLR;
            clr_addr_reg   <= '0;
            clr_pend_reg   <= 1'b0;
            scan_first_reg <= 1'b0;
            mex_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            clr_pend_reg   <= clr_pend_next;
            scan_first_reg <= scan_first_next;
            mex_reg        <= mex_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        value_reg       <= value_next;
        word_reg        <= word_next;
        scan_addr_reg   <= scan_addr_next;
        res_outcome_reg <= res_outcome_next;
        res_oor_reg     <= res_oor_next;
        out_outcome_reg <= out_outcome_next;
        out_mex_reg     <= out_mex_next;
        out_oor_reg     <= out_oor_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.outcome      = out_outcome_reg;
    assign rsp.mex_value    = out_mex_reg;
    assign rsp.out_of_range = out_oor_reg;

    // The mex never passes the set size
    a_mex_bound: assert property (@(posedge clk) disable iff (!rst_n)
        EXT_W'(mex_reg) <= SIZE_EXT)
        else $error("mex beyond set size");

    // An out-of-range command leaves the mex alone
    a_oor_keeps_mex: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.cmd != CMD_CLEAR && in_oor) |=> $stable(mex_reg))
        else $error("out-of-range command moved the mex");

    // A finished clear reports an empty set
    a_clear_mex: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && cmd_reg == CMD_CLEAR) |-> (mex_reg == '0))
        else $error("clear left a non-zero mex");

    // The scan only reads the bitmap
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !ram_we)
        else $error("bitmap written during scan");

    // Out-of-range responses never claim an effect
    a_oor_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.out_of_range) |-> !rsp.outcome)
        else $error("out-of-range response with outcome set");
endmodule

@@ rtl/core/mexset_ram.sv @@
`timescale 1ns / 1ps

module mexset_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
